// File: rtl/core/decayed_linear_regression_macros.svh
// ----------------------------------------------------------------------------
// decayed linear regression assertion macros
// shared concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef DECAYED_LINEAR_REGRESSION_MACROS_SVH
`define DECAYED_LINEAR_REGRESSION_MACROS_SVH

// same-cycle implication
`define DLR_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// next-cycle implication
`define DLR_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// types and constants shared by the regression controller and datapath
// ----------------------------------------------------------------------------
package dlr_pkg;

    // fraction bits of the running sums
    localparam int FRAC_BITS = 32;

    // running sum widths
    localparam int CNT_W = 36;
    localparam int SX_W  = 45;
    localparam int SY_W  = 45;
    localparam int SXX_W = 50;
    localparam int SXY_W = 51;

    // wide arithmetic widths
    localparam int SUM_W    = 64;   // sample add and saturate
    localparam int OPD_W    = 52;   // signed multiplier operand
    localparam int MAG_W    = 51;   // operand magnitude
    localparam int CHUNK_W  = 13;   // multiplier slice of b
    localparam int NCHUNK   = 4;
    localparam int CHK_W    = 2;
    localparam int PP_W     = MAG_W + CHUNK_W;
    localparam int MUL_W    = MAG_W + CHUNK_W * NCHUNK + 1;
    localparam int ACC_W    = 98;   // det and numerators
    localparam int DIV_W    = 120;  // remainder and shifted divisor
    localparam int Q_W      = 34;   // quotient incl. overflow bits
    localparam int DSTEPS   = Q_W;
    localparam int STEP_W   = 6;
    localparam int SEL_W    = 3;
    localparam int NSUMS    = 5;
    localparam int DEC_W    = 16;
    localparam int FIT_W    = 32;
    localparam int ADDR_W   = 8;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_DECAY   = 8'd0;
    localparam logic [ADDR_W-1:0] REG_MIN_DET = 8'd1;

    // sum select codes
    localparam logic [SEL_W-1:0] SEL_CNT = 3'd0;
    localparam logic [SEL_W-1:0] SEL_SX  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_SY  = 3'd2;
    localparam logic [SEL_W-1:0] SEL_SXX = 3'd3;
    localparam logic [SEL_W-1:0] SEL_SXY = 3'd4;

    // product terms, in issue order
    typedef enum logic [2:0] {
        MUL_N_SXX  = 3'd0,
        MUL_SX_SX  = 3'd1,
        MUL_SXY_N  = 3'd2,
        MUL_SX_SY  = 3'd3,
        MUL_SXX_SY = 3'd4,
        MUL_SXY_SX = 3'd5
    } mul_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic             capture;
        logic             decay_mul;
        logic             decay_add;
        logic [SEL_W-1:0] sel;
        logic             mac_en;
        logic             acc_clr;
        mul_op_t          mul_op;
        logic [CHK_W-1:0] chunk;
        logic             det_save;
        logic             div_load;
        logic             div_step;
        logic             fit_wr;
        logic             fit_sel;
        logic             out_load;
        logic             upd;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic det_ok;
    } dp_sts_t;

endpackage

// File: rtl/core/decayed_linear_regression.sv
// ----------------------------------------------------------------------------
// decayed_linear_regression
// exponentially weighted online least-squares line fit, one word per sample
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      x_sample, y_sample
//  m_axis    out        m_axis_tvalid/tready      slope, intercept; tuser update
//  cfg       in         cfg_valid/cfg_ready       cfg_addr, cfg_data
//
//  a sample without a refit runs the five decay multiplies, then the determinant
//  on the 51x13 slice multiplier and its check, then the output load. with a
//  refit, each fit coefficient between check and load takes its products, a
//  divider load, restoring divider steps for a 34-bit quotient and a fit write.
//  the next sample can be taken from the cycle after the output load.
//  the result sits in an output register, so the next sample is taken while
//  it waits; a stalled output holds the sequencer at its final step.
//  reset is asynchronous, clears sums, fit and control, and needs no sweep.
// ----------------------------------------------------------------------------
module decayed_linear_regression
    import dlr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // x_sample [15:0], y_sample [31:16]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // slope_out [31:0], intercept_out [63:32]
    output logic              m_axis_tuser,   // fit_updated [0]
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [DEC_W-1:0]  cfg_data
);

    dp_cmd_t                 cmd;
    dp_sts_t                 sts;
    logic signed [FIT_W-1:0] slope_w;
    logic signed [FIT_W-1:0] icpt_w;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // sequencer
    dlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic
    dlr_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .x_sample      (s_axis_tdata[15:0]),
        .y_sample      (s_axis_tdata[31:16]),
        .cmd           (cmd),
        .sts           (sts),
        .slope_out     (slope_w),
        .intercept_out (icpt_w),
        .fit_updated   (m_axis_tuser)
    );

    assign m_axis_tdata = {icpt_w, slope_w};

endmodule

// File: rtl/core/dlr_datapath.sv
// ----------------------------------------------------------------------------
// dlr_datapath
// running sums, shared slice multiplier, accumulator and serial divider
// ----------------------------------------------------------------------------
module dlr_datapath
    import dlr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [ADDR_W-1:0]        cfg_addr,
    input  logic [DEC_W-1:0]         cfg_data,
    input  logic signed [15:0]       x_sample,
    input  logic signed [15:0]       y_sample,
    input  dp_cmd_t                  cmd,
    output dp_sts_t                  sts,
    output logic signed [FIT_W-1:0]  slope_out,
    output logic signed [FIT_W-1:0]  intercept_out,
    output logic                     fit_updated
);

    // configuration registers
    logic [DEC_W-1:0] decay_reg;
    logic [DEC_W-1:0] min_det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg   <= 16'd53656;
            min_det_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DECAY:   decay_reg   <= cfg_data;
                REG_MIN_DET: min_det_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // state sums and fit
    logic        [CNT_W-1:0]  cnt_reg;
    logic signed [SX_W-1:0]   sx_reg;
    logic signed [SY_W-1:0]   sy_reg;
    logic        [SXX_W-1:0]  sxx_reg;
    logic signed [SXY_W-1:0]  sxy_reg;
    logic signed [FIT_W-1:0]  slope_reg;
    logic signed [FIT_W-1:0]  icpt_reg;

    // captured sample terms
    logic signed [15:0] xs_reg;
    logic signed [15:0] ys_reg;
    logic signed [31:0] xx_reg;
    logic signed [31:0] xy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            xs_reg <= x_sample;
            ys_reg <= y_sample;
            xx_reg <= x_sample * x_sample;
            xy_reg <= x_sample * y_sample;
        end
    end

    // saturation helpers
    function automatic logic signed [SUM_W-1:0] sat_s(input logic signed [SUM_W-1:0] v,
                                                      input int w);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = (SUM_W'(1) <<< (w - 1)) - SUM_W'(1);
        lo = -hi - SUM_W'(1);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_u(input logic signed [SUM_W-1:0] v,
                                                      input int w);
        logic signed [SUM_W-1:0] hi;
        hi = (SUM_W'(1) <<< w) - SUM_W'(1);
        return (v > hi) ? hi : ((v < 0) ? '0 : v);
    endfunction

    // sum as a signed 64-bit value
    logic signed [SUM_W-1:0] cur_sum;

    always_comb
    begin
        case (cmd.sel)
            SEL_CNT: cur_sum = SUM_W'(cnt_reg);
            SEL_SX:  cur_sum = SUM_W'(sx_reg);
            SEL_SY:  cur_sum = SUM_W'(sy_reg);
            SEL_SXX: cur_sum = SUM_W'(sxx_reg);
            default: cur_sum = SUM_W'(sxy_reg);
        endcase
    end

    // decay multiply, rounded to nearest on the magnitude
    logic                        dneg_reg;
    logic [MAG_W+DEC_W-1:0]      dprod_reg;
    logic [MAG_W-1:0]            dmag;

    assign dmag = cur_sum[SUM_W-1] ? MAG_W'(-cur_sum) : MAG_W'(cur_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.decay_mul)
        begin
            dneg_reg  <= cur_sum[SUM_W-1];
            dprod_reg <= dmag * decay_reg + (MAG_W+DEC_W)'(17'h8000);
        end
    end

    // sample term and saturated new sum
    logic signed [SUM_W-1:0] dval;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] nsum;

    always_comb
    begin
        dval = dneg_reg ? -SUM_W'(dprod_reg[MAG_W+DEC_W-1:DEC_W])
                        :  SUM_W'(dprod_reg[MAG_W+DEC_W-1:DEC_W]);
        case (cmd.sel)
            SEL_CNT: term = SUM_W'(1) <<< FRAC_BITS;
            SEL_SX:  term = SUM_W'(xs_reg) <<< (FRAC_BITS - 8);
            SEL_SY:  term = SUM_W'(ys_reg) <<< (FRAC_BITS - 8);
            SEL_SXX: term = SUM_W'(xx_reg) <<< (FRAC_BITS - 16);
            default: term = SUM_W'(xy_reg) <<< (FRAC_BITS - 16);
        endcase
        case (cmd.sel)
            SEL_CNT: nsum = sat_u(dval + term, CNT_W);
            SEL_SX:  nsum = sat_s(dval + term, SX_W);
            SEL_SY:  nsum = sat_s(dval + term, SY_W);
            SEL_SXX: nsum = sat_u(dval + term, SXX_W);
            default: nsum = sat_s(dval + term, SXY_W);
        endcase
    end

    // product operand selection
    logic signed [OPD_W-1:0] op_a;
    logic signed [OPD_W-1:0] op_b;
    logic                    op_sub;

    always_comb
    begin
        case (cmd.mul_op)
            MUL_N_SXX:
            begin
                op_a = OPD_W'(cnt_reg); op_b = OPD_W'(sxx_reg); op_sub = 1'b0;
            end
            MUL_SX_SX:
            begin
                op_a = OPD_W'(sx_reg);  op_b = OPD_W'(sx_reg);  op_sub = 1'b1;
            end
            MUL_SXY_N:
            begin
                op_a = OPD_W'(sxy_reg); op_b = OPD_W'(cnt_reg); op_sub = 1'b0;
            end
            MUL_SX_SY:
            begin
                op_a = OPD_W'(sx_reg);  op_b = OPD_W'(sy_reg);  op_sub = 1'b1;
            end
            MUL_SXX_SY:
            begin
                op_a = OPD_W'(sxx_reg); op_b = OPD_W'(sy_reg);  op_sub = 1'b0;
            end
            default:
            begin
                op_a = OPD_W'(sxy_reg); op_b = OPD_W'(sx_reg);  op_sub = 1'b1;
            end
        endcase
    end

    // one slice of b per cycle into the accumulator
    logic [MAG_W-1:0]            a_mag;
    logic [CHUNK_W*NCHUNK-1:0]   b_mag;
    logic [CHUNK_W-1:0]          b_slice;
    logic [PP_W-1:0]             pp;
    logic signed [MUL_W-1:0]     pp_sh;
    logic signed [MUL_W-1:0]     pp_term;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_base;

    always_comb
    begin
        a_mag    = op_a[OPD_W-1] ? MAG_W'(-op_a) : MAG_W'(op_a);
        b_mag    = op_b[OPD_W-1] ? (CHUNK_W*NCHUNK)'(-op_b) : (CHUNK_W*NCHUNK)'(op_b);
        b_slice  = b_mag[cmd.chunk*CHUNK_W +: CHUNK_W];
        pp       = a_mag * b_slice;
        pp_sh    = MUL_W'(pp) << (cmd.chunk * CHUNK_W);
        pp_term  = (op_a[OPD_W-1] ^ op_b[OPD_W-1] ^ op_sub) ? -pp_sh : pp_sh;
        acc_base = cmd.acc_clr ? '0 : acc_reg;
    end

    // determinant check against threshold
    logic signed [ACC_W-1:0] det_reg;
    logic signed [ACC_W-1:0] thr;

    assign thr        = ACC_W'(min_det_reg) <<< FRAC_BITS;
    assign sts.det_ok = acc_reg > thr;

    // restoring divider, one quotient bit a cycle
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic             qneg_reg;
    logic [ACC_W-1:0] acc_mag;
    logic             ge;

    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign ge      = rem_reg >= dsh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mac_en)
            acc_reg <= acc_base + ACC_W'(pp_term);
        if (cmd.det_save)
            det_reg <= acc_reg;
        if (cmd.div_load)
        begin
            rem_reg  <= DIV_W'({acc_mag, 16'b0});
            dsh_reg  <= DIV_W'({det_reg, 33'b0});
            q_reg    <= '0;
            qneg_reg <= acc_reg[ACC_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? rem_reg - dsh_reg : rem_reg;
            q_reg   <= {q_reg[Q_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // saturated quotient
    logic [Q_W-1:0]          q_lim;
    logic [Q_W-1:0]          q_sat;
    logic signed [FIT_W-1:0] q_res;

    always_comb
    begin
        q_lim = qneg_reg ? Q_W'(34'h080000000) : Q_W'(34'h07FFFFFFF);
        q_sat = (q_reg > q_lim) ? q_lim : q_reg;
        q_res = qneg_reg ? FIT_W'(-q_sat) : FIT_W'(q_sat);
    end

    // sums and fit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            sxy_reg   <= '0;
            slope_reg <= '0;
            icpt_reg  <= '0;
        end
        else
        begin
            if (cmd.decay_add)
            begin
                case (cmd.sel)
                    SEL_CNT: cnt_reg <= nsum[CNT_W-1:0];
                    SEL_SX:  sx_reg  <= nsum[SX_W-1:0];
                    SEL_SY:  sy_reg  <= nsum[SY_W-1:0];
                    SEL_SXX: sxx_reg <= nsum[SXX_W-1:0];
                    default: sxy_reg <= nsum[SXY_W-1:0];
                endcase
            end
            if (cmd.fit_wr)
            begin
                if (cmd.fit_sel)
                    icpt_reg <= q_res;
                else
                    slope_reg <= q_res;
            end
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            slope_out     <= slope_reg;
            intercept_out <= icpt_reg;
            fit_updated   <= cmd.upd;
        end
    end

endmodule

// File: rtl/core/dlr_ctrl.sv
// ----------------------------------------------------------------------------
// dlr_ctrl
// sequencer for decay, products, determinant check and the two divisions
// ----------------------------------------------------------------------------
module dlr_ctrl
    import dlr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    `include "decayed_linear_regression_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE,
        S_DMUL,
        S_DADD,
        S_MAC,
        S_DETCHK,
        S_DLOAD,
        S_DSTEP,
        S_FITWR,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [SEL_W-1:0]  sel_reg;
    mul_op_t           op_reg;
    logic [CHK_W-1:0]  chunk_reg;
    logic [STEP_W-1:0] step_reg;
    logic              fit_sel_reg;
    logic              upd_reg;
    logic              out_valid_reg;
    logic              out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // command decode
    always_comb
    begin
        cmd           = '0;
        cmd.sel       = sel_reg;
        cmd.mul_op    = op_reg;
        cmd.chunk     = chunk_reg;
        cmd.fit_sel   = fit_sel_reg;
        cmd.upd       = upd_reg;
        cmd.capture   = (state_reg == S_IDLE) && in_valid;
        cmd.decay_mul = (state_reg == S_DMUL);
        cmd.decay_add = (state_reg == S_DADD);
        cmd.mac_en    = (state_reg == S_MAC);
        cmd.acc_clr   = (state_reg == S_MAC) && (chunk_reg == '0)
                        && (op_reg == MUL_N_SXX || op_reg == MUL_SXY_N
                            || op_reg == MUL_SXX_SY);
        cmd.det_save  = (state_reg == S_DETCHK);
        cmd.div_load  = (state_reg == S_DLOAD);
        cmd.div_step  = (state_reg == S_DSTEP);
        cmd.fit_wr    = (state_reg == S_FITWR);
        cmd.out_load  = (state_reg == S_OUT) && out_free;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= '0;
            op_reg        <= MUL_N_SXX;
            chunk_reg     <= '0;
            step_reg      <= '0;
            fit_sel_reg   <= 1'b0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sel_reg   <= SEL_CNT;
                        state_reg <= S_DMUL;
                    end
                end
                S_DMUL:
                    state_reg <= S_DADD;
                S_DADD:
                begin
                    if (sel_reg == SEL_SXY)
                    begin
                        op_reg    <= MUL_N_SXX;
                        chunk_reg <= '0;
                        state_reg <= S_MAC;
                    end
                    else
                    begin
                        sel_reg   <= sel_reg + SEL_W'(1);
                        state_reg <= S_DMUL;
                    end
                end
                S_MAC:
                begin
                    chunk_reg <= chunk_reg + CHK_W'(1);
                    if (chunk_reg == CHK_W'(NCHUNK - 1))
                    begin
                        unique case (op_reg)
                            MUL_SX_SX:  state_reg <= S_DETCHK;
                            MUL_SX_SY:  state_reg <= S_DLOAD;
                            MUL_SXY_SX: state_reg <= S_DLOAD;
                            default:    op_reg <= mul_op_t'(op_reg + 3'd1);
                        endcase
                    end
                end
                S_DETCHK:
                begin
                    upd_reg <= sts.det_ok;
                    if (sts.det_ok)
                    begin
                        op_reg      <= MUL_SXY_N;
                        chunk_reg   <= '0;
                        fit_sel_reg <= 1'b0;
                        state_reg   <= S_MAC;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_DLOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DSTEP;
                end
                S_DSTEP:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DSTEPS - 1))
                        state_reg <= S_FITWR;
                end
                S_FITWR:
                begin
                    if (!fit_sel_reg)
                    begin
                        fit_sel_reg <= 1'b1;
                        op_reg      <= MUL_SXX_SY;
                        chunk_reg   <= '0;
                        state_reg   <= S_MAC;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `DLR_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_reg == S_DMUL)
    `DLR_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)
    `DLR_ASSERT_IMP(a_div_after_fit, clk, rst_n, state_reg == S_DLOAD, upd_reg)
    `DLR_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid_reg && state_reg == S_IDLE)

endmodule
